// ----- rtl/i2cmts_pkg.sv -----
// Package for the I2C master transfer sequencer: transaction structs, command,
// phase, outcome, completion and controller status codes.
// No dependencies.
package i2cmts_pkg;

   // command codes
   localparam logic [2:0] CMD_LOAD   = 3'd0;
   localparam logic [2:0] CMD_WRITE  = 3'd1;
   localparam logic [2:0] CMD_READ   = 3'd2;
   localparam logic [2:0] CMD_STATUS = 3'd3;
   localparam logic [2:0] CMD_ABORT  = 3'd4;

   // transfer phase codes
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_WRITE = 3'd1;
   localparam logic [2:0] PH_READ  = 3'd2;
   localparam logic [2:0] PH_DONE  = 3'd3;
   localparam logic [2:0] PH_ERROR = 3'd4;

   // outcome codes
   localparam logic [1:0] OUT_OK       = 2'd0;
   localparam logic [1:0] OUT_BUS_ERR  = 2'd1;
   localparam logic [1:0] OUT_BUSY     = 2'd2;
   localparam logic [1:0] OUT_BAD_LEN  = 2'd3;

   // completion codes
   localparam logic [1:0] CMPL_NONE  = 2'd0;
   localparam logic [1:0] CMPL_WRITE = 2'd1;
   localparam logic [1:0] CMPL_READ  = 2'd2;
   localparam logic [1:0] CMPL_ERROR = 2'd3;

   // controller status codes that are acted on; all others are bus errors
   localparam logic [7:0] ST_START      = 8'h08;
   localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
   localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
   localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;
   localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
   localparam logic [7:0] ST_DATA_R_NAK = 8'h58;

   typedef struct packed {
      logic [2:0] cmd;
      logic [6:0] slave_address;
      logic [7:0] byte_count;
      logic       send_stop;
      logic [7:0] buffer_index;
      logic [7:0] load_byte;
      logic [7:0] status_code;
      logic [7:0] bus_byte;
   } req_type;

   typedef struct packed {
      logic       data_write_valid;
      logic [7:0] data_out;
      logic       clear_flag;
      logic       ack_next;
      logic       issue_stop;
      logic       issue_start;
      logic       rx_valid;
      logic [7:0] rx_index;
      logic [7:0] rx_byte;
      logic [2:0] phase;
      logic [1:0] outcome;
      logic [1:0] completion;
   } rsp_type;

   // transmit buffer access for one transaction
   typedef struct packed {
      logic       wr_en;
      logic [7:0] wr_index;
      logic [7:0] wr_byte;
      logic       rd_en;
      logic [7:0] rd_index;
   } txbuf_req_type;

   // decoded transaction waiting for the buffer read to return
   typedef struct packed {
      rsp_type rsp;
      logic    use_mem;
   } stage_type;

endpackage

// ----- rtl/i2cmts_txbuf.sv -----
// Transmit byte buffer: one write port, one read port, registered read data.
// Depends on i2cmts_pkg.
module i2cmts_txbuf #(
   parameter int TX_DEPTH = 256
) (
   input  logic                      clock,
   input  i2cmts_pkg::txbuf_req_type req,
   output logic [7:0]                rd_data
);
   localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

   logic [7:0] mem [TX_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_index[AW-1:0]] <= req.wr_byte;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_index[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/i2cmts_ctrl.sv -----
// Transfer state registers and per-transaction decode of commands and
// controller status codes. Depends on i2cmts_pkg.
module i2cmts_ctrl #(
   parameter int TX_DEPTH = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  i2cmts_pkg::req_type       req,
   output i2cmts_pkg::stage_type     stage,
   output i2cmts_pkg::txbuf_req_type buf_req
);
   localparam logic [8:0] DEPTH_LIM = 9'(TX_DEPTH);

   logic [2:0] phase_ff, phase_in;
   logic [6:0] target_ff, target_in;
   logic [7:0] wlen_ff, wlen_in;
   logic [7:0] wpos_ff, wpos_in;
   logic [7:0] rlen_ff, rlen_in;
   logic [7:0] rpos_ff, rpos_in;
   logic       stop_ff, stop_in;
   logic       last_ff, last_in;

   logic       rejected;
   logic [1:0] rej_code;
   logic       busy;
   i2cmts_pkg::rsp_type res;

   always_comb begin
      phase_in  = phase_ff;
      target_in = target_ff;
      wlen_in   = wlen_ff;
      wpos_in   = wpos_ff;
      rlen_in   = rlen_ff;
      rpos_in   = rpos_ff;
      stop_in   = stop_ff;
      last_in   = last_ff;
      rejected  = 1'b0;
      rej_code  = i2cmts_pkg::OUT_OK;
      res       = '0;
      stage.use_mem = 1'b0;
      buf_req   = '0;
      busy = (phase_ff == i2cmts_pkg::PH_WRITE) || (phase_ff == i2cmts_pkg::PH_READ);

      case (req.cmd)
         i2cmts_pkg::CMD_LOAD: begin
            buf_req.wr_en    = accept && ({1'b0, req.buffer_index} < DEPTH_LIM);
            buf_req.wr_index = req.buffer_index;
            buf_req.wr_byte  = req.load_byte;
         end
         i2cmts_pkg::CMD_WRITE, i2cmts_pkg::CMD_READ: begin
            if (req.byte_count == 8'd0) begin
               rejected = 1'b1;
               rej_code = i2cmts_pkg::OUT_BAD_LEN;
            end else if (busy) begin
               rejected = 1'b1;
               rej_code = i2cmts_pkg::OUT_BUSY;
            end else begin
               target_in = req.slave_address;
               wpos_in   = 8'd0;
               rpos_in   = 8'd0;
               wlen_in   = (req.cmd == i2cmts_pkg::CMD_WRITE) ? req.byte_count : 8'd0;
               rlen_in   = (req.cmd == i2cmts_pkg::CMD_READ) ? req.byte_count : 8'd0;
               stop_in   = req.send_stop;
               last_in   = 1'b0;
               phase_in  = (req.cmd == i2cmts_pkg::CMD_WRITE) ? i2cmts_pkg::PH_WRITE
                                                              : i2cmts_pkg::PH_READ;
               res.issue_start = 1'b1;
            end
         end
         i2cmts_pkg::CMD_STATUS: begin
            if (busy) begin
               case (req.status_code)
                  i2cmts_pkg::ST_START: begin
                     res.data_write_valid = 1'b1;
                     res.data_out = {target_ff, phase_ff != i2cmts_pkg::PH_WRITE};
                     res.clear_flag = 1'b1;
                  end
                  i2cmts_pkg::ST_ADDR_W_ACK, i2cmts_pkg::ST_DATA_W_ACK: begin
                     if (wpos_ff < wlen_ff) begin
                        res.data_write_valid = 1'b1;
                        res.clear_flag = 1'b1;
                        // positions past the buffer send zero
                        stage.use_mem  = ({1'b0, wpos_ff} < DEPTH_LIM);
                        buf_req.rd_en  = accept && stage.use_mem;
                        buf_req.rd_index = wpos_ff;
                        wpos_in = wpos_ff + 8'd1;
                     end else begin
                        phase_in = i2cmts_pkg::PH_DONE;
                        res.issue_stop = stop_ff;
                        res.completion = i2cmts_pkg::CMPL_WRITE;
                     end
                  end
                  i2cmts_pkg::ST_ADDR_R_ACK: begin
                     res.clear_flag = 1'b1;
                     res.ack_next = (rlen_ff > 8'd1);
                  end
                  i2cmts_pkg::ST_DATA_R_ACK: begin
                     res.rx_valid = 1'b1;
                     res.rx_index = rpos_ff;
                     res.rx_byte  = req.bus_byte;
                     if (rpos_ff != 8'hFF) begin
                        rpos_in = rpos_ff + 8'd1;
                     end
                     res.clear_flag = 1'b1;
                     res.ack_next = (({1'b0, rpos_in} + 9'd1) < {1'b0, rlen_ff});
                  end
                  i2cmts_pkg::ST_DATA_R_NAK: begin
                     res.rx_valid = 1'b1;
                     res.rx_index = rpos_ff;
                     res.rx_byte  = req.bus_byte;
                     if (rpos_ff != 8'hFF) begin
                        rpos_in = rpos_ff + 8'd1;
                     end
                     phase_in = i2cmts_pkg::PH_DONE;
                     res.issue_stop = stop_ff;
                     res.completion = i2cmts_pkg::CMPL_READ;
                  end
                  default: begin
                     phase_in = i2cmts_pkg::PH_ERROR;
                     last_in  = 1'b1;
                     res.issue_stop = 1'b1;
                     res.clear_flag = 1'b1;
                     res.completion = i2cmts_pkg::CMPL_ERROR;
                  end
               endcase
            end
         end
         i2cmts_pkg::CMD_ABORT: begin
            res.issue_stop = 1'b1;
            phase_in = i2cmts_pkg::PH_ERROR;
         end
         default: begin
         end
      endcase

      res.phase   = phase_in;
      res.outcome = rejected ? rej_code : {1'b0, last_in};
      stage.rsp   = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= i2cmts_pkg::PH_IDLE;
         target_ff <= '0;
         wlen_ff   <= '0;
         wpos_ff   <= '0;
         rlen_ff   <= '0;
         rpos_ff   <= '0;
         stop_ff   <= 1'b0;
         last_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         target_ff <= target_in;
         wlen_ff   <= wlen_in;
         wpos_ff   <= wpos_in;
         rlen_ff   <= rlen_in;
         rpos_ff   <= rpos_in;
         stop_ff   <= stop_in;
         last_ff   <= last_in;
      end
   end
endmodule

// ----- rtl/i2c_master_transfer_sequencer.sv -----
// Top level of the I2C master transfer sequencer: decode stage, transmit
// buffer and output register. Depends on i2cmts_pkg, i2cmts_ctrl, i2cmts_txbuf.
//
//   channel | ports                         | direction | payload
//   req     | req_valid/req_ready/req_data  | in        | i2cmts_pkg::req_type
//   rsp     | rsp_valid/rsp_ready/rsp_data  | out       | i2cmts_pkg::rsp_type
//
// One transaction per cycle unless responses stall; each response passes the
// decode stage (decode plus transmit buffer read), then the output register.
// Reset clears the transfer state to idle; the buffer holds no reset value.
// A stalled response holds in the output register while one more request
// waits in the decode stage; req_ready drops only when both are full.
module i2c_master_transfer_sequencer #(
   parameter int TX_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cmts_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cmts_pkg::rsp_type rsp_data
);
   logic accept;
   logic out_load;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   i2cmts_pkg::stage_type     stage;
   i2cmts_pkg::stage_type     s1_ff;
   i2cmts_pkg::txbuf_req_type buf_req;
   i2cmts_pkg::rsp_type       rsp_ff, rsp_in;
   logic [7:0]                rd_data;

   i2cmts_ctrl #(.TX_DEPTH(TX_DEPTH)) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .stage   (stage),
      .buf_req (buf_req)
   );

   i2cmts_txbuf #(.TX_DEPTH(TX_DEPTH)) u_txbuf (
      .clock   (clock),
      .req     (buf_req),
      .rd_data (rd_data)
   );

   assign out_load  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || out_load;
   assign accept    = req_valid && req_ready;

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (out_load ? 1'b0 : s1_valid_ff);
      rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_in = s1_ff.rsp;
      // buffer read data lands in the cycle after the decode
      if (s1_ff.use_mem) begin
         rsp_in.data_out = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= stage;
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ----- rtl/i2cmts_checker.sv -----
// Port-level checks for the I2C master transfer sequencer, bound to the top.
// Depends on i2cmts_pkg and i2c_master_transfer_sequencer.
module i2cmts_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input i2cmts_pkg::rsp_type rsp_data
);
   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_start_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.issue_start |->
         (rsp_data.phase == i2cmts_pkg::PH_WRITE || rsp_data.phase == i2cmts_pkg::PH_READ)
         && rsp_data.outcome == i2cmts_pkg::OUT_OK)
      else $error("start without an active transfer");

   a_err_cmpl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.completion == i2cmts_pkg::CMPL_ERROR |->
         rsp_data.phase == i2cmts_pkg::PH_ERROR && rsp_data.issue_stop
         && rsp_data.outcome == i2cmts_pkg::OUT_BUS_ERR)
      else $error("bus error completion inconsistent");

   a_rx_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rx_valid |->
         rsp_data.phase == i2cmts_pkg::PH_WRITE || rsp_data.phase == i2cmts_pkg::PH_READ
         || rsp_data.phase == i2cmts_pkg::PH_DONE)
      else $error("received byte outside a transfer");

   a_dout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.data_write_valid |-> rsp_data.data_out == 8'd0)
      else $error("data_out set without a data write");
endmodule

bind i2c_master_transfer_sequencer i2cmts_checker u_i2cmts_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
